// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_AT(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_AT(label, clk, rstn, prop)
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/b2da_pkg.sv =====
`default_nettype none
package b2da_pkg;
	localparam int VALUE_W        = 32;
	localparam int STEP_W         = $clog2(VALUE_W);
	localparam int DIGIT_W        = 4;
	localparam int CHAR_W         = 6;
	localparam int IN_TDATA_W     = 32;
	localparam int OUT_TDATA_W    = 8;
	localparam int MAX_DIGITS_DEF = 10;

	localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(VALUE_W - 1);
	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SKIP,
		ST_EMIT
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/core/b2da_dabble.sv =====
`default_nettype none
// One shift-and-add-3 step: every BCD digit of 5 or more gets 3 added, then
// the whole register shifts left by one with the next binary bit entering.
module b2da_dabble #(
	parameter int DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
	input  wire logic [4*DIGITS-1:0] bcd,
	input  wire logic                bit_in,
	output logic      [4*DIGITS-1:0] bcd_next
);
	import b2da_pkg::*;

	localparam int BCD_W = DIGIT_W * DIGITS;

	logic [BCD_W-1:0] adjusted;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				adjusted[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				adjusted[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	assign bcd_next = {adjusted[BCD_W-2:0], bit_in};
endmodule
`default_nettype wire

// ===== rtl/core/binary_to_decimal_ascii_top.sv =====
// The first character is valid after the item passes the conversion, the leading
// zero skip and the output register. An item takes one pass through the add-3/shift
// unit per input bit, a one-digit-per-cycle leading zero skip and one character per
// cycle out when the output is not stalled; a new item is accepted only once the
// previous item's last character has been loaded into the output register.
// Reset: arst_n clears the sequencer and the output valid flag asynchronously.
`default_nettype none
`include "assert_macros.svh"
module binary_to_decimal_ascii_top #(
	parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [b2da_pkg::IN_TDATA_W-1:0]      s_tdata,  // [31:0] value
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic      [b2da_pkg::OUT_TDATA_W-1:0]     m_tdata,  // [5:0] character, [7:6] zero
	output logic                                      m_tlast
);
	import b2da_pkg::*;

	localparam int BCD_W = DIGIT_W * MAX_DIGITS;
	localparam int REM_W = $clog2(MAX_DIGITS + 1);

	state_t                state_q, state_d;
	logic [VALUE_W-1:0]    bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_next;
	logic [STEP_W-1:0]     step_q;
	logic [REM_W-1:0]      rem_q;
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     out_char_q;
	logic                  out_last_q;

	logic [DIGIT_W-1:0]    top_digit;
	logic                  accept;
	logic                  convert;
	logic                  more_zeros;
	logic                  skip_shift;
	logic                  emit;
	logic                  last_digit;

	b2da_dabble #(
		.DIGITS(MAX_DIGITS)
	) u_dabble (
		.bcd      (bcd_q),
		.bit_in   (bin_q[VALUE_W-1]),
		.bcd_next (bcd_next)
	);

	assign top_digit  = bcd_q[BCD_W-1 -: DIGIT_W];
	assign more_zeros = (top_digit == '0) && (rem_q > REM_W'(1));
	assign last_digit = (rem_q == REM_W'(1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_CONVERT;
			end
			ST_CONVERT: begin
				if (step_q == STEP_LAST) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (!more_zeros) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if ((!out_valid_q || m_tready) && last_digit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		s_tready   = 1'b0;
		convert    = 1'b0;
		skip_shift = 1'b0;
		emit       = 1'b0;
		case (state_q)
			ST_IDLE:    s_tready   = 1'b1;
			ST_CONVERT: convert    = 1'b1;
			ST_SKIP:    skip_shift = more_zeros;
			ST_EMIT:    emit       = !out_valid_q || m_tready;
			default:    s_tready   = 1'b0;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q  <= s_tdata[VALUE_W-1:0];
			bcd_q  <= '0;
			step_q <= '0;
		end else if (convert) begin
			bcd_q  <= bcd_next;
			bin_q  <= bin_q << 1;
			step_q <= step_q + STEP_W'(1);
			rem_q  <= REM_W'(MAX_DIGITS);
		end else if (skip_shift || emit) begin
			// Move the next digit into the top position.
			bcd_q <= bcd_q << DIGIT_W;
			rem_q <= rem_q - REM_W'(1);
		end
		if (emit) begin
			out_char_q <= ASCII_ZERO | CHAR_W'(top_digit);
			out_last_q <= last_digit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_char_q);
	assign m_tlast  = out_last_q;

	`ASSERT_IMPL(a_char_is_digit, clk, arst_n, m_tvalid,
		(m_tdata[CHAR_W-1:0] >= ASCII_ZERO) && (m_tdata[CHAR_W-1:0] <= ASCII_ZERO + CHAR_W'(9)))
	`ASSERT_IMPL(a_rem_nonzero, clk, arst_n, (state_q == ST_SKIP) || (state_q == ST_EMIT),
		rem_q != '0)
	`ASSERT_NEXT(a_accept_starts, clk, arst_n, accept,
		(state_q == ST_CONVERT) && (step_q == '0))
endmodule
`default_nettype wire
